// File: rtl/fcpa_pkg.sv
`default_nettype none
package fcpa_pkg;

  localparam int PADDR_W = 4;
  localparam int DATA_W  = 32;
  localparam int CHUNK_W = 16;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_REBUILD = 2'd2;

  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_CHUNK  = 2'd2;
  localparam logic [1:0] REG_ALIGN  = 2'd3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_OOB      = 3'd2,
    ST_NULL     = 3'd3,
    ST_MISALIGN = 3'd4,
    ST_BADCFG   = 3'd5
  } status_e;

  typedef struct packed {
    logic                go;
    logic [DATA_W-1:0]   dividend;
    logic [CHUNK_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DATA_W-1:0]   quotient;
    logic [CHUNK_W-1:0]  remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/fcpa_ram.sv
`default_nettype none
module fcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/fcpa_div.sv
`default_nettype none
module fcpa_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fcpa_pkg::div_req_t  req_i,
  output fcpa_pkg::div_rsp_t  rsp_o
);
  import fcpa_pkg::*;

  logic [DATA_W-1:0]  dvd_q;
  logic [CHUNK_W-1:0] dsr_q;
  logic [CHUNK_W-1:0] rem_q;
  logic [4:0]         cnt_q;
  logic               active_q;
  logic               done_q;

  logic [CHUNK_W:0]   trial;
  logic               fits;
  logic [CHUNK_W:0]   rem_next;

  always_comb begin
    trial    = {rem_q, dvd_q[DATA_W-1]};
    fits     = trial >= {1'b0, dsr_q};
    rem_next = fits ? trial - {1'b0, dsr_q} : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q    <= '0;
      dsr_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        dvd_q    <= req_i.dividend;
        dsr_q    <= req_i.divisor;
        rem_q    <= '0;
        cnt_q    <= '0;
        active_q <= 1'b1;
      end else if (active_q) begin
        dvd_q <= {dvd_q[DATA_W-2:0], fits};
        rem_q <= rem_next[CHUNK_W-1:0];
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == '1) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule
`default_nettype wire

// File: rtl/fixed_chunk_pool_allocator_top.sv
`default_nettype none
// Fixed-size chunk pool with a LIFO free list. Pulse start with mode_i and
// address_i while busy is low; exactly one result follows on chunk_address_o
// and status_o, marked by done_o for a single cycle, and it cannot be held
// off, so the receiver must take it in that cycle. An alloc does one
// link-memory read. A free and a rebuild both run the offset or the
// usable length through a shared 1-bit-per-cycle divider (32 steps), and
// a rebuild then sweeps the link memory, writing one link per cycle.
// Configure the pool through the APB port while the block is idle.
module fixed_chunk_pool_allocator_top #(
  parameter int MAX_CHUNKS = 1024,
  parameter int ADDR_WIDTH = 32,
  parameter int NODE_BYTES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcpa_pkg::PADDR_W-1:0]  paddr,
  input  logic [fcpa_pkg::DATA_W-1:0]   pwdata,
  output logic [fcpa_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode_i,
  input  logic [31:0]                   address_i,
  output logic                          done_o,
  output logic [31:0]                   chunk_address_o,
  output logic [2:0]                    status_o
);
  import fcpa_pkg::*;

  localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int LINK_W = $clog2(MAX_CHUNKS + 1);
  localparam int PROD_W = LINK_W + CHUNK_W;
  localparam int SHW    = (ADDR_WIDTH < 33) ? ADDR_WIDTH : 33;
  localparam logic [LINK_W-1:0] NULL_IDX = LINK_W'(MAX_CHUNKS);
  localparam logic [33:0] SPACE = (ADDR_WIDTH <= 32) ? (34'd1 << ADDR_WIDTH) : '1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_AL_RD,
    S_AL_OUT,
    S_FR_CHK,
    S_FR_DIV,
    S_RB_USE,
    S_RB_CLIP,
    S_RB_CHK,
    S_RB_DIV,
    S_RB_FILL
  } state_e;

  // configuration
  logic [31:0]        base_q;
  logic [31:0]        len_q;
  logic [CHUNK_W-1:0] chunk_bytes_q;
  logic [3:0]         align_q;

  // pool state
  logic [LINK_W-1:0]  free_head_q;
  logic [32:0]        pool_start_q;
  logic [31:0]        usable_len_q;
  logic [CHUNK_W-1:0] rc_q;
  logic [LINK_W-1:0]  total_q;

  // working registers
  state_e             state_q;
  logic [1:0]         mode_q;
  logic [31:0]        addr_q;
  logic [32:0]        start_q;
  logic [16:0]        chunk_q;
  logic [31:0]        usable_q;
  logic [31:0]        off_q;
  logic [PROD_W-1:0]  prod_q;
  logic [LINK_W-1:0]  fill_q;
  logic               div_go_q;

  // result
  logic               done_q;
  logic [31:0]        res_addr_q;
  status_e            status_q;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [LINK_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [LINK_W-1:0]  ram_rdata;

  logic               cfg_wr;
  logic [32:0]        align_m;
  logic [32:0]        start_calc;
  logic [16:0]        chunk_calc;
  logic [32:0]        pad;
  logic [33:0]        pool_end;
  logic [32:0]        free_off;
  logic [32:0]        alloc_sum;
  logic               free_ok;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_BASE:   prdata = base_q;
      REG_LENGTH: prdata = len_q;
      REG_CHUNK:  prdata = {{(DATA_W - CHUNK_W){1'b0}}, chunk_bytes_q};
      REG_ALIGN:  prdata = {28'd0, align_q};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    align_m    = (33'd1 << align_q) - 33'd1;
    start_calc = ({1'b0, base_q} + align_m) & ~align_m;
    chunk_calc = ({1'b0, chunk_bytes_q} + align_m[16:0]) & ~align_m[16:0];
    pad        = start_q - {1'b0, base_q};
    pool_end   = {1'b0, start_q} + {2'b00, usable_q};
    free_off   = {1'b0, addr_q} - pool_start_q;
    alloc_sum  = pool_start_q + 33'(prod_q);
    free_ok    = (div_rsp.remainder == '0) && (div_rsp.quotient < 32'(total_q));
  end

  always_comb begin
    div_req.go       = div_go_q;
    div_req.dividend = (state_q == S_RB_DIV) ? usable_q : off_q;
    div_req.divisor  = (state_q == S_RB_DIV) ? chunk_q[CHUNK_W-1:0] : rc_q;
  end

  fcpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = div_rsp.quotient[IDX_W-1:0];
    ram_wdata = free_head_q;
    ram_re    = (state_q == S_AL_RD);
    ram_raddr = free_head_q[IDX_W-1:0];
    if (state_q == S_FR_DIV) begin
      ram_we = div_rsp.done && free_ok;
    end else if (state_q == S_RB_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = fill_q[IDX_W-1:0];
      ram_wdata = (fill_q == '0) ? NULL_IDX : fill_q - LINK_W'(1);
    end
  end

  fcpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_CHUNKS)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q        <= '0;
      len_q         <= '0;
      chunk_bytes_q <= 16'd16;
      align_q       <= 4'd2;
      free_head_q   <= NULL_IDX;
      pool_start_q  <= '0;
      usable_len_q  <= '0;
      rc_q          <= '0;
      total_q       <= '0;
      state_q       <= S_IDLE;
      mode_q        <= '0;
      addr_q        <= '0;
      start_q       <= '0;
      chunk_q       <= '0;
      usable_q      <= '0;
      off_q         <= '0;
      prod_q        <= '0;
      fill_q        <= '0;
      div_go_q      <= 1'b0;
      done_q        <= 1'b0;
      res_addr_q    <= '0;
      status_q      <= ST_OK;
    end else begin
      done_q   <= 1'b0;
      div_go_q <= 1'b0;

      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_BASE:   base_q        <= pwdata;
          REG_LENGTH: len_q         <= pwdata;
          REG_CHUNK:  chunk_bytes_q <= pwdata[CHUNK_W-1:0];
          REG_ALIGN:  align_q       <= pwdata[3:0];
          default:    base_q        <= base_q;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            mode_q  <= mode_i;
            addr_q  <= address_i;
            state_q <= S_DECODE;
          end
        end

        S_DECODE: begin
          if (mode_q == MODE_ALLOC) begin
            if (free_head_q >= NULL_IDX) begin
              done_q     <= 1'b1;
              res_addr_q <= '0;
              status_q   <= ST_EMPTY;
              state_q    <= S_IDLE;
            end else begin
              state_q <= S_AL_RD;
            end
          end else if (mode_q == MODE_FREE) begin
            state_q <= S_FR_CHK;
          end else if (mode_q == MODE_REBUILD) begin
            pool_start_q <= '0;
            usable_len_q <= '0;
            rc_q         <= '0;
            total_q      <= '0;
            free_head_q  <= NULL_IDX;
            start_q      <= start_calc;
            chunk_q      <= chunk_calc;
            state_q      <= S_RB_USE;
          end else begin
            done_q     <= 1'b1;
            res_addr_q <= '0;
            status_q   <= ST_OK;
            state_q    <= S_IDLE;
          end
        end

        S_AL_RD: begin
          prod_q  <= PROD_W'(free_head_q) * PROD_W'(rc_q);
          state_q <= S_AL_OUT;
        end

        S_AL_OUT: begin
          free_head_q <= ram_rdata;
          done_q      <= 1'b1;
          res_addr_q  <= alloc_sum[31:0];
          status_q    <= ST_OK;
          state_q     <= S_IDLE;
        end

        S_FR_CHK: begin
          if (addr_q == '0) begin
            done_q     <= 1'b1;
            res_addr_q <= '0;
            status_q   <= ST_NULL;
            state_q    <= S_IDLE;
          end else if (({1'b0, addr_q} < pool_start_q) ||
                       (free_off[31:0] >= usable_len_q) || (rc_q == '0)) begin
            done_q     <= 1'b1;
            res_addr_q <= '0;
            status_q   <= ST_OOB;
            state_q    <= S_IDLE;
          end else begin
            off_q    <= free_off[31:0];
            div_go_q <= 1'b1;
            state_q  <= S_FR_DIV;
          end
        end

        S_FR_DIV: begin
          if (div_rsp.done) begin
            done_q     <= 1'b1;
            res_addr_q <= '0;
            state_q    <= S_IDLE;
            if (div_rsp.remainder != '0) begin
              status_q <= ST_MISALIGN;
            end else if (!free_ok) begin
              status_q <= ST_OOB;
            end else begin
              free_head_q <= div_rsp.quotient[LINK_W-1:0];
              status_q    <= ST_OK;
            end
          end
        end

        S_RB_USE: begin
          if ((|(start_q >> SHW)) || (pad > {1'b0, len_q})) begin
            done_q     <= 1'b1;
            res_addr_q <= '0;
            status_q   <= ST_BADCFG;
            state_q    <= S_IDLE;
          end else begin
            usable_q <= len_q - pad[31:0];
            state_q  <= S_RB_CLIP;
          end
        end

        S_RB_CLIP: begin
          if (pool_end > SPACE) begin
            usable_q <= 32'(SPACE - {1'b0, start_q});
          end
          state_q <= S_RB_CHK;
        end

        S_RB_CHK: begin
          if ((chunk_q > 17'h0FFFF) || (chunk_q < 17'(NODE_BYTES)) ||
              (usable_q < 32'(chunk_q))) begin
            done_q     <= 1'b1;
            res_addr_q <= '0;
            status_q   <= ST_BADCFG;
            state_q    <= S_IDLE;
          end else begin
            div_go_q <= 1'b1;
            state_q  <= S_RB_DIV;
          end
        end

        S_RB_DIV: begin
          if (div_rsp.done) begin
            pool_start_q <= start_q;
            usable_len_q <= usable_q;
            rc_q         <= chunk_q[CHUNK_W-1:0];
            total_q      <= (div_rsp.quotient > 32'(MAX_CHUNKS)) ?
                            NULL_IDX : div_rsp.quotient[LINK_W-1:0];
            fill_q       <= '0;
            state_q      <= S_RB_FILL;
          end
        end

        S_RB_FILL: begin
          if (fill_q == total_q - LINK_W'(1)) begin
            free_head_q <= fill_q;
            done_q      <= 1'b1;
            res_addr_q  <= '0;
            status_q    <= ST_OK;
            state_q     <= S_IDLE;
          end else begin
            fill_q <= fill_q + LINK_W'(1);
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign chunk_address_o = res_addr_q;
  assign status_o        = status_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= NULL_IDX)
    else $error("free list head out of range");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (chunk_address_o == '0))
    else $error("nonzero address on a failed transfer");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RB_FILL) |-> (fill_q < total_q))
    else $error("link sweep past chunk count");
`endif

endmodule
`default_nettype wire

// File: test/fcpa_checker.sv
`timescale 1ns / 1ps
module fcpa_checker #(
  parameter int MAX_CHUNKS = 1024,
  parameter int ADDR_WIDTH = 32,
  parameter int NODE_BYTES = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fcpa_pkg::PADDR_W-1:0] paddr,
  input  logic [fcpa_pkg::DATA_W-1:0]  pwdata,
  input  logic                         pready,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   mode_i,
  input  logic [31:0]                  address_i,
  input  logic                         done_o,
  input  logic [31:0]                  chunk_address_o,
  input  logic [2:0]                   status_o,
  output int                           fail_count,
  output int                           pending_count
);
  import fcpa_pkg::*;

  localparam logic [63:0] ADDR_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - ADDR_WIDTH);
  localparam int NULL_IDX = MAX_CHUNKS;

  typedef struct packed {
    logic [31:0] chunk_address;
    status_e     status;
  } reply_t;

  reply_t reply_q[$];

  logic [31:0] base_r;
  logic [31:0] length_r;
  logic [15:0] chunk_r;
  logic [3:0]  align_r;

  int          free_head;
  int          next_link [MAX_CHUNKS];
  logic [63:0] pool_start;
  logic [63:0] usable_len;
  logic [63:0] slot_bytes;
  int          chunk_total;

  function automatic logic [63:0] align_up(input logic [63:0] v, input logic [63:0] al);
    logic [63:0] rem;
    rem = v & (al - 64'd1);
    return (rem != 0) ? v + (al - rem) : v;
  endfunction

  task automatic rebuild_pool(output status_e st);
    logic [63:0] al;
    logic [63:0] first;
    logic [63:0] pad;
    logic [63:0] usable;
    logic [63:0] ck;
    logic [63:0] n;
    al    = 64'd1 << align_r;
    first = align_up(64'(base_r), al);
    pad   = first - 64'(base_r);
    free_head   = NULL_IDX;
    pool_start  = '0;
    usable_len  = '0;
    slot_bytes  = '0;
    chunk_total = 0;
    st = ST_BADCFG;
    if (first > ADDR_MASK || pad > 64'(length_r)) return;
    usable = 64'(length_r) - pad;
    // clip so the pool ends inside the address space
    if (usable != 0 && usable - 64'd1 > ADDR_MASK - first) usable = ADDR_MASK - first + 64'd1;
    ck = align_up(64'(chunk_r), al);
    if (ck > 64'hFFFF || ck < NODE_BYTES || usable < ck) return;
    n = usable / ck;
    if (n > MAX_CHUNKS) n = MAX_CHUNKS;
    pool_start  = first;
    usable_len  = usable;
    slot_bytes  = ck;
    chunk_total = int'(n);
    for (int i = 0; i < chunk_total; i++) begin
      next_link[i] = free_head;
      free_head = i;
    end
    st = ST_OK;
  endtask

  task automatic predict_reply(input logic [1:0] md, input logic [31:0] ad,
                               output reply_t rep);
    logic [63:0] off;
    logic [63:0] idx;
    logic [63:0] addr;
    status_e     st;
    rep.chunk_address = '0;
    rep.status = ST_OK;
    case (md)
      MODE_ALLOC: begin
        if (free_head >= NULL_IDX) begin
          rep.status = ST_EMPTY;
        end else begin
          addr = pool_start + 64'(free_head) * slot_bytes;
          rep.chunk_address = addr[31:0];
          free_head = next_link[free_head];
        end
      end
      MODE_FREE: begin
        if (ad == 0) begin
          rep.status = ST_NULL;
        end else if (64'(ad) < pool_start || 64'(ad) - pool_start >= usable_len ||
                     slot_bytes == 0) begin
          rep.status = ST_OOB;
        end else begin
          off = 64'(ad) - pool_start;
          idx = off / slot_bytes;
          if (off % slot_bytes != 0) begin
            rep.status = ST_MISALIGN;
          end else if (idx >= 64'(chunk_total)) begin
            rep.status = ST_OOB;
          end else begin
            next_link[idx] = free_head;
            free_head = int'(idx);
          end
        end
      end
      MODE_REBUILD: begin
        rebuild_pool(st);
        rep.status = st;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      base_r        = '0;
      length_r      = '0;
      chunk_r       = 16'd16;
      align_r       = 4'd2;
      free_head     = NULL_IDX;
      pool_start    = '0;
      usable_len    = '0;
      slot_bytes    = '0;
      chunk_total   = 0;
      reply_q.delete();
      fail_count    = 0;
      pending_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BASE:   base_r   = pwdata;
          REG_LENGTH: length_r = pwdata;
          REG_CHUNK:  chunk_r  = pwdata[15:0];
          REG_ALIGN:  align_r  = pwdata[3:0];
          default: ;
        endcase
      end
      if (done_o) begin
        if (reply_q.size() == 0) begin
          $error("unexpected result: chunk_address %h status %0d", chunk_address_o, status_o);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (chunk_address_o !== want.chunk_address) begin
            $error("chunk_address expected %h actual %h", want.chunk_address, chunk_address_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        predict_reply(mode_i, address_i, want);
        reply_q.push_back(want);
      end
      pending_count = reply_q.size();
    end
  end

endmodule

// File: test/fixed_chunk_pool_allocator_top_tb.sv
`timescale 1ns / 1ps
module fixed_chunk_pool_allocator_top_tb;
  import fcpa_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_TARGET = 1350;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                start;
  logic                busy;
  logic [1:0]          mode_i;
  logic [31:0]         address_i;
  logic                done_o;
  logic [31:0]         chunk_address_o;
  logic [2:0]          status_o;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int sent = 0;

  logic [63:0] pool_base;
  logic [63:0] pool_chunk;
  logic [63:0] pool_slots;

  always #5 clk_i = ~clk_i;

  fixed_chunk_pool_allocator_top i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .start,
    .busy,
    .mode_i,
    .address_i,
    .done_o,
    .chunk_address_o,
    .status_o
  );

  fcpa_checker i_checker (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .pready,
    .start,
    .busy,
    .mode_i,
    .address_i,
    .done_o,
    .chunk_address_o,
    .status_o,
    .fail_count,
    .pending_count
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] align_up(input logic [63:0] v, input logic [63:0] al);
    logic [63:0] rem;
    rem = v & (al - 64'd1);
    return (rem != 0) ? v + (al - rem) : v;
  endfunction

  task automatic send_item(input logic [1:0] md, input logic [31:0] ad);
    bit quiet;
    quiet = (sent >= 500 && sent < 720);
    if (!quiet && $urandom_range(0, 99) < 29) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start     = 1'b1;
    mode_i    = md;
    address_i = ad;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (pending_count != 0 || busy) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // reprogram while idle, then rebuild
  task automatic configure(input logic [31:0] b, input logic [31:0] l,
                           input logic [15:0] c, input logic [3:0] a);
    wait_idle();
    repeat (2) @(negedge clk_i);
    reg_write(REG_BASE, b);
    reg_write(REG_LENGTH, l);
    reg_write(REG_CHUNK, {16'($urandom), c});
    reg_write(REG_ALIGN, {28'($urandom), a});
    pool_base  = align_up(64'(b), 64'd1 << a);
    pool_chunk = align_up(64'(c), 64'd1 << a);
    pool_slots = (pool_chunk != 0) ? 64'(l) / pool_chunk : 64'd0;
    if (pool_slots > 1100) pool_slots = 1100;
    send_item(MODE_REBUILD, $urandom);
  endtask

  function automatic logic [31:0] free_target();
    int          r;
    logic [63:0] a;
    r = $urandom_range(0, 99);
    if (pool_chunk == 0 || r >= 90) return $urandom;
    a = pool_base + 64'($urandom_range(0, int'(pool_slots) + 1)) * pool_chunk;
    if (r < 65) return a[31:0];
    if (r < 73) return '0;
    if (r < 83) return a[31:0] + 32'($urandom_range(1, int'(pool_chunk > 1 ? pool_chunk - 1 : 1)));
    return pool_base[31:0] - 32'($urandom_range(1, 64));
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 47)      send_item(MODE_ALLOC, $urandom);
    else if (r < 91) send_item(MODE_FREE, free_target());
    else if (r < 96) send_item(MODE_REBUILD, $urandom);
    else             send_item(MODE_UNUSED, $urandom);
  endtask

  task automatic random_phase();
    int          kind;
    logic [31:0] b;
    logic [31:0] l;
    logic [15:0] c;
    logic [3:0]  a;
    logic [63:0] ck;
    logic [63:0] span;
    kind = $urandom_range(0, 9);
    a = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 6));
    c = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 200));
    b = $urandom;
    ck = align_up(64'(c), 64'd1 << a);
    case (kind)
      0: l = $urandom;
      1: begin
        b = 32'hFFFF_FFFF - 32'($urandom_range(0, 4095));
        l = $urandom;
      end
      default: begin
        b = $urandom & 32'h7FFF_FFFF;
        span = ck * 64'($urandom_range(1, 40)) + 64'($urandom_range(0, 1 << a));
        if (ck != 0) span = span + 64'($urandom) % ck;
        l = span[31:0];
      end
    endcase
    configure(b, l, c, a);
    repeat ($urandom_range(20, 60)) random_item();
  endtask

  initial begin
    rst_ni    = 1'b0;
    start     = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    mode_i    = MODE_ALLOC;
    address_i = '0;
    pool_base  = '0;
    pool_chunk = '0;
    pool_slots = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_item(MODE_ALLOC, '0);
    send_item(MODE_FREE, '0);
    send_item(MODE_FREE, 32'hFFFF_FFFF);
    send_item(MODE_UNUSED, 32'h8000_0000);
    send_item(MODE_REBUILD, '0);

    configure(32'h0000_1003, 32'h0000_0100, 16'd10, 4'd3);
    send_item(MODE_ALLOC, '0);
    send_item(MODE_ALLOC, '0);
    send_item(MODE_FREE, 32'h0000_10E8);
    send_item(MODE_FREE, 32'h0000_1009);
    send_item(MODE_FREE, 32'h0000_1000);
    send_item(MODE_FREE, 32'h0000_1103);
    send_item(MODE_FREE, 32'h0000_10F8);

    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd16, 4'd4);
    configure(32'h0000_0001, 32'h0000_0005, 16'd16, 4'd4);
    configure(32'h0000_0000, 32'h1000_0000, 16'hFFFF, 4'd4);
    configure(32'h0000_0000, 32'h0000_0100, 16'd1, 4'd0);

    configure(32'hFFFF_FF00, 32'hFFFF_FFFF, 16'd64, 4'd6);
    send_item(MODE_ALLOC, '0);
    send_item(MODE_FREE, 32'hFFFF_FFC0);

    configure(32'h0000_0000, 32'hFFFF_FFFF, 16'd4, 4'd0);
    send_item(MODE_FREE, 32'd6000);
    send_item(MODE_ALLOC, '0);

    while (sent < ITEM_TARGET) random_phase();

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/fcpa_pkg.sv
rtl/fcpa_ram.sv
rtl/fcpa_div.sv
rtl/fixed_chunk_pool_allocator_top.sv
test/fcpa_checker.sv
test/fixed_chunk_pool_allocator_top_tb.sv
